// File: rtl/lpr_pkg.sv
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared types and fixed field widths of the LRU page replacement unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lpr_pkg;

    localparam int CFG_W       = 4;
    localparam int FRAME_IDX_W = 3;
    localparam int FAULT_W     = 32;

    localparam logic [CFG_W-1:0]   CFG_RESET = 4'd8;
    localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

endpackage

`default_nettype wire

// File: rtl/lpr_if.sv
// ----------------------------------------------------------------------------
// lpr_if
// Request and response channels of the LRU page replacement unit.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpr_req_if #(
    parameter int PAGE_BITS = 16
);
    logic                 valid;
    logic                 ready;
    logic [PAGE_BITS-1:0] page;

    modport source (output valid, output page, input ready);
    modport sink   (input valid, input page, output ready);
endinterface

interface lpr_rsp_if #(
    parameter int PAGE_BITS = 16
);
    import lpr_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   hit;
    logic [FRAME_IDX_W-1:0] frame_index;
    logic                   evicted_valid;
    logic [PAGE_BITS-1:0]   evicted_page;
    logic [FAULT_W-1:0]     fault_count;

    modport source (
        output valid, output hit, output frame_index, output evicted_valid,
        output evicted_page, output fault_count, input ready
    );
    modport sink (
        input valid, input hit, input frame_index, input evicted_valid,
        input evicted_page, input fault_count, output ready
    );
endinterface

`default_nettype wire

// File: rtl/lru_page_replacement_unit.sv
// ----------------------------------------------------------------------------
// lru_page_replacement_unit
// LRU page frame tracker: lookup, fill and least-recently-used eviction.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one page reference per request (valid/ready). o_rsp returns
//   one response per request: hit, frame index, evicted page and the running
//   fault count. i_cfg_we/i_cfg_wdata write the number of active frames
//   (0 acts as 1, values above FRAMES act as FRAMES); write it only while idle.
//   After accept, one compare unit walks the n active frames one per cycle
//   through the single read port of the page and stamp memories, whose read
//   data is registered, then an update step writes the chosen frame and
//   loads the response register; the next request is taken only after that.
//   The response sits in an output register; if the sink stalls, the next
//   request is still taken and scanned, and its update waits until the
//   register is free.
//   Reset empties all frames and clears the use clock and the fault count;
//   the frame count returns to 8. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_page_replacement_unit #(
    parameter int FRAMES     = 8,
    parameter int PAGE_BITS  = 16,
    parameter int STAMP_BITS = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [lpr_pkg::CFG_W-1:0] i_cfg_wdata,
    lpr_req_if.sink                       i_req,
    lpr_rsp_if.source                     o_rsp
);
    import lpr_pkg::*;

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W = $clog2(FRAMES + 1);
    localparam int NW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    t_state                r_state;
    logic [CFG_W-1:0]      r_cfg;
    logic [PAGE_BITS-1:0]  r_req_page;
    logic [CNT_W-1:0]      r_idx;
    logic                  r_cmp_vld;
    logic [IDX_W-1:0]      r_cmp_idx;
    logic                  r_found;
    logic [IDX_W-1:0]      r_hit_at;
    logic                  r_have_free;
    logic [IDX_W-1:0]      r_free_at;
    logic [IDX_W-1:0]      r_old_at;
    logic [STAMP_BITS-1:0] r_old_stamp;
    logic [PAGE_BITS-1:0]  r_old_page;
    logic [FRAMES-1:0]     r_valid;
    logic [STAMP_BITS-1:0] r_clock;
    logic [FAULT_W-1:0]    r_fault;

    logic [PAGE_BITS-1:0]  r_page_mem  [FRAMES];
    logic [STAMP_BITS-1:0] r_stamp_mem [FRAMES];
    logic [PAGE_BITS-1:0]  r_rd_page;
    logic [STAMP_BITS-1:0] r_rd_stamp;

    logic                   r_out_vld;
    logic                   r_out_hit;
    logic [FRAME_IDX_W-1:0] r_out_frame;
    logic                   r_out_ev_vld;
    logic [PAGE_BITS-1:0]   r_out_ev_page;
    logic [FAULT_W-1:0]     r_out_fault;

    t_state                n_state;
    logic [NW-1:0]         w_cfg_ext;
    logic [CNT_W-1:0]      w_n;
    logic                  w_accept;
    logic                  w_issue;
    logic                  w_go;
    logic                  w_cmp_valid;
    logic [STAMP_BITS-1:0] w_cmp_stamp;
    logic [IDX_W-1:0]      w_target;
    logic [STAMP_BITS-1:0] w_clk_next;
    logic [FAULT_W-1:0]    w_fault_next;

    // active frame count, clamped to 1..FRAMES
    always_comb begin
        w_cfg_ext = NW'(r_cfg);
        if (r_cfg == '0) begin
            w_n = CNT_W'(1);
        end else if (w_cfg_ext > NW'(FRAMES)) begin
            w_n = CNT_W'(FRAMES);
        end else begin
            w_n = CNT_W'(r_cfg);
        end
    end

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_issue     = (r_state == ST_SCAN) && (r_idx < w_n);
    assign w_go        = (r_state == ST_DONE) && (!r_out_vld || o_rsp.ready);

    // an empty frame was never stamped, so its stamp reads as zero
    assign w_cmp_valid = r_valid[r_cmp_idx];
    assign w_cmp_stamp = w_cmp_valid ? r_rd_stamp : '0;

    always_comb begin
        if (r_found) begin
            w_target = r_hit_at;
        end else if (r_have_free) begin
            w_target = r_free_at;
        end else begin
            w_target = r_old_at;
        end
        w_clk_next   = (r_clock == '1) ? r_clock : r_clock + 1'b1;
        w_fault_next = (r_fault == FAULT_MAX) ? r_fault : r_fault + 1'b1;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (!w_issue) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_go) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cfg       <= CFG_RESET;
            r_idx       <= '0;
            r_cmp_vld   <= 1'b0;
            r_found     <= 1'b0;
            r_have_free <= 1'b0;
            r_valid     <= '0;
            r_clock     <= '0;
            r_fault     <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= w_issue;
            if (i_cfg_we) r_cfg <= i_cfg_wdata;

            if (w_accept) begin
                r_idx       <= '0;
                r_found     <= 1'b0;
                r_have_free <= 1'b0;
            end else if (w_issue) begin
                r_idx <= r_idx + 1'b1;
            end

            if (r_cmp_vld) begin
                if (w_cmp_valid && !r_found && (r_rd_page == r_req_page)) begin
                    r_found <= 1'b1;
                end
                if (!w_cmp_valid && !r_have_free) begin
                    r_have_free <= 1'b1;
                end
            end

            if (w_go) begin
                r_valid[w_target] <= 1'b1;
                r_clock           <= w_clk_next;
                if (!r_found) r_fault <= w_fault_next;
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // scan payload: hit, first empty and oldest frame
    always_ff @(posedge i_clk) begin
        if (w_accept) r_req_page <= i_req.page;
        r_cmp_idx <= r_idx[IDX_W-1:0];
        if (r_cmp_vld) begin
            if (w_cmp_valid && !r_found && (r_rd_page == r_req_page)) begin
                r_hit_at <= r_cmp_idx;
            end
            if (!w_cmp_valid && !r_have_free) begin
                r_free_at <= r_cmp_idx;
            end
            if ((r_cmp_idx == '0) || (w_cmp_stamp < r_old_stamp)) begin
                r_old_stamp <= w_cmp_stamp;
                r_old_at    <= r_cmp_idx;
                r_old_page  <= r_rd_page;
            end
        end
    end

    // frame memories: one read port for the scan, one write port for update
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_rd_page  <= r_page_mem[r_idx[IDX_W-1:0]];
            r_rd_stamp <= r_stamp_mem[r_idx[IDX_W-1:0]];
        end
        if (w_go) begin
            r_stamp_mem[w_target] <= w_clk_next;
            if (!r_found) r_page_mem[w_target] <= r_req_page;
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_out_hit     <= r_found;
            r_out_frame   <= FRAME_IDX_W'(w_target);
            r_out_ev_vld  <= !r_found && !r_have_free;
            r_out_ev_page <= (!r_found && !r_have_free) ? r_old_page : '0;
            r_out_fault   <= r_found ? r_fault : w_fault_next;
        end
    end

    assign o_rsp.valid         = r_out_vld;
    assign o_rsp.hit           = r_out_hit;
    assign o_rsp.frame_index   = r_out_frame;
    assign o_rsp.evicted_valid = r_out_ev_vld;
    assign o_rsp.evicted_page  = r_out_ev_page;
    assign o_rsp.fault_count   = r_out_fault;

    a_fault_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_fault >= $past(r_fault)))
        else $error("fault count decreased");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.hit) |-> !o_rsp.evicted_valid)
        else $error("hit reported an eviction");

    a_accept_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_SCAN) && (r_idx == '0))
        else $error("accepted request did not start a scan");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DONE) && r_out_vld && !o_rsp.ready) |=>
            (r_state == ST_DONE) && $stable(r_out_fault))
        else $error("update overran a held response");

    a_target_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go |=> r_valid[$past(w_target)])
        else $error("updated frame not marked valid");

endmodule

`default_nettype wire
